FILE: hw/rtl/nearest_smaller_max_diff_unit_defines.svh
// Assertion macros shared by the checker of the nearest smaller max diff unit.
// No dependencies; the including module must have clk and rst in scope.
`ifndef NEAREST_SMALLER_MAX_DIFF_UNIT_DEFINES_SVH
`define NEAREST_SMALLER_MAX_DIFF_UNIT_DEFINES_SVH

// Next-cycle implication, ignored while reset is asserted.
`define NSMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsmd checker: next-cycle property failed");

// Next-cycle implication that is also checked across reset.
`define NSMD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nsmd checker: property across reset failed");

`endif

FILE: hw/rtl/nsmd_pkg.sv
// Shared types for the nearest smaller max diff unit.
// Command and status groups between the controller and the datapath; no dependencies.
package nsmd_pkg;

  typedef struct packed {
    logic latch_in;    // capture the incoming request
    logic pop;         // drop the stack top and fetch the entry below it
    logic load_top;    // take the fetched stack entry as the new top
    logic push;        // push the current value onto the stack
    logic store;       // record value and left neighbor of a new element
    logic hold_nb;     // keep the right neighbor and step the element index down
    logic right_init;  // start the right-to-left pass
    logic rd_elem;     // fetch one stored element and its left neighbor
    logic load_elem;   // take the fetched element as the current value
    logic diff;        // fold one neighbor difference into the running maximum
    logic finish;      // publish the result and clear the frame
  } cmd_t;

  typedef struct packed {
    logic pop_needed;  // stack not empty and its top is not smaller than the value
    logic room;        // frame still has space for an element
    logic last_flag;   // the captured request closes the frame
    logic idx_zero;    // right pass has visited every element
    logic out_busy;    // result register still holds an untaken result
  } status_t;

endpackage

FILE: hw/rtl/nsmd_datapath.sv
// Datapath of the nearest smaller max diff unit: element, neighbor and stack memories.
// Depends on nsmd_pkg for the command and status structs.
module nsmd_datapath #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nsmd_pkg::cmd_t                cmd,
  output nsmd_pkg::status_t             status,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  output logic        [VALUE_WIDTH-1:0] max_diff,
  output logic                          result_valid,
  input  logic                          result_stall
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int W  = VALUE_WIDTH;

  logic signed [W-1:0] value_mem [0:MAX_ELEMENTS-1];
  logic signed [W-1:0] left_mem  [0:MAX_ELEMENTS-1];
  logic signed [W-1:0] stack_mem [0:MAX_ELEMENTS-1];

  logic [CW-1:0]       sp;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [W:0]          running_max;
  logic signed [W-1:0] cur;
  logic                last_q;
  logic signed [W-1:0] top;
  logic signed [W-1:0] left_val;
  logic signed [W-1:0] nb_reg;
  logic signed [W-1:0] stack_rdata;
  logic signed [W-1:0] value_rdata;
  logic signed [W-1:0] left_rdata;

  logic signed [W-1:0] nb_c;
  logic [CW-1:0]       sp_m2;
  logic [CW-1:0]       idx_m1;
  logic [W:0]          d;
  logic [W:0]          d_abs;

  assign nb_c   = (sp != '0) ? top : '0;
  assign sp_m2  = sp - CW'(2);
  assign idx_m1 = idx - CW'(1);
  assign d      = {left_val[W-1], left_val} - {nb_reg[W-1], nb_reg};
  assign d_abs  = d[W] ? (~d + (W+1)'(1)) : d;

  assign status.pop_needed = (sp != '0) && (top >= cur);
  assign status.room       = (count < CW'(MAX_ELEMENTS));
  assign status.last_flag  = last_q;
  assign status.idx_zero   = (idx == '0);
  assign status.out_busy   = result_valid;

  // Stack memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[sp[AW-1:0]] <= cur;
    end
    if (cmd.pop) begin
      stack_rdata <= stack_mem[sp_m2[AW-1:0]];
    end
  end

  // Element and left-neighbor memories share one address stream.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      value_mem[count[AW-1:0]] <= cur;
      left_mem[count[AW-1:0]]  <= nb_c;
    end
    if (cmd.rd_elem) begin
      value_rdata <= value_mem[idx_m1[AW-1:0]];
      left_rdata  <= left_mem[idx_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur    <= value;
      last_q <= last;
    end else if (cmd.load_elem) begin
      cur <= value_rdata;
    end
    if (cmd.load_elem) begin
      left_val <= left_rdata;
    end
    if (cmd.push) begin
      top <= cur;
    end else if (cmd.load_top) begin
      top <= stack_rdata;
    end
    if (cmd.hold_nb) begin
      nb_reg <= nb_c;
    end
    if (cmd.finish) begin
      max_diff <= running_max[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      count        <= '0;
      idx          <= '0;
      running_max  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.right_init || cmd.finish) begin
        sp <= '0;
      end else if (cmd.push) begin
        sp <= sp + CW'(1);
      end else if (cmd.pop) begin
        sp <= sp - CW'(1);
      end
      if (cmd.finish) begin
        count <= '0;
      end else if (cmd.store) begin
        count <= count + CW'(1);
      end
      if (cmd.right_init) begin
        idx <= count;
      end else if (cmd.hold_nb) begin
        idx <= idx_m1;
      end
      if (cmd.right_init || cmd.finish) begin
        running_max <= '0;
      end else if (cmd.diff && (d_abs > running_max)) begin
        running_max <= d_abs;
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/nsmd_ctrl.sv
// Controller of the nearest smaller max diff unit: sequences loading and the right pass.
// Depends on nsmd_pkg for the command and status structs.
module nsmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  nsmd_pkg::status_t status,
  output nsmd_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_LWAIT  = 4'd2;
  localparam logic [3:0] S_RINIT  = 4'd3;
  localparam logic [3:0] S_RREAD  = 4'd4;
  localparam logic [3:0] S_RELEM  = 4'd5;
  localparam logic [3:0] S_RCHECK = 4'd6;
  localparam logic [3:0] S_RWAIT  = 4'd7;
  localparam logic [3:0] S_DIFF   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!status.room) begin
          state_next = status.last_flag ? S_RINIT : S_IDLE;
        end else if (status.pop_needed) begin
          cmd.pop    = 1'b1;
          state_next = S_LWAIT;
        end else begin
          cmd.push   = 1'b1;
          cmd.store  = 1'b1;
          state_next = status.last_flag ? S_RINIT : S_IDLE;
        end
      end
      S_LWAIT: begin
        cmd.load_top = 1'b1;
        state_next   = S_LOAD;
      end
      S_RINIT: begin
        cmd.right_init = 1'b1;
        state_next     = S_RREAD;
      end
      S_RREAD: begin
        cmd.rd_elem = 1'b1;
        state_next  = S_RELEM;
      end
      S_RELEM: begin
        cmd.load_elem = 1'b1;
        state_next    = S_RCHECK;
      end
      S_RCHECK: begin
        if (status.pop_needed) begin
          cmd.pop    = 1'b1;
          state_next = S_RWAIT;
        end else begin
          cmd.push    = 1'b1;
          cmd.hold_nb = 1'b1;
          state_next  = S_DIFF;
        end
      end
      S_RWAIT: begin
        cmd.load_top = 1'b1;
        state_next   = S_RCHECK;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = status.idx_zero ? S_FINISH : S_RREAD;
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/nearest_smaller_max_diff_unit.sv
// Top level of the nearest smaller max diff unit.
// Instantiates nsmd_ctrl and nsmd_datapath; uses nsmd_pkg for the shared structs.
//
// Usage: a frame of signed values arrives on the item channel (value, last), one
// request per element; the request with last high closes the frame. One result
// request, max_diff, leaves on the result channel for each closed frame. It holds
// the largest |left smaller - right smaller| over the frame, a missing neighbor
// counting as zero. Elements beyond MAX_ELEMENTS are dropped; their last still closes.
// Sequencing: a loading element pops each stack entry not smaller than it, and every
// pop waits on the registered read of the single-port stack memory. Closing starts
// the right-to-left pass over the stored elements, then the result is published
// and shows in the output register in the following cycle. Over a frame each pass
// pops at most once per element.
// item_stall is low only while the controller waits for a new element.
// Reset clears the stack pointer, the element count, the running maximum and the
// result flag; the memories need no clearing because only written entries are read.
// A stalled result holds in its output register while the next frame loads; a
// frame that closes before that result is taken waits until the register is free.
module nearest_smaller_max_diff_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic        [VALUE_WIDTH-1:0] max_diff
);

  nsmd_pkg::cmd_t    cmd;
  nsmd_pkg::status_t status;

  // The controller owns sequencing and the input handshake.
  nsmd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the memories, the stack and the result register.
  nsmd_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .last         (last),
    .max_diff     (max_diff),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

FILE: hw/rtl/nsmd_checker.sv
// Port-level checker for the nearest smaller max diff unit, bound to the top level.
// Depends on nearest_smaller_max_diff_unit_defines.svh for the assertion macros.
`include "nearest_smaller_max_diff_unit_defines.svh"

module nsmd_port_checker #(
  parameter int VALUE_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [VALUE_WIDTH-1:0] max_diff
);

  // A stalled result stays offered with the same value.
  `NSMD_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
  `NSMD_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(max_diff))
  // Every accepted element keeps the block busy for at least the next cycle.
  `NSMD_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
  // Reset leaves no result offered.
  `NSMD_ASSERT_NEXT_ALWAYS(a_reset_clears_result, rst, !result_valid)

endmodule

bind nearest_smaller_max_diff_unit nsmd_port_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_nsmd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .max_diff     (max_diff)
);

FILE: tb/nsmd_checker.sv
// Checker for the nearest smaller max diff unit: watches both channels, keeps its
// own predictor of the frame state and compares every result request with it.
// Depends only on the port widths of the unit; no package types are needed.
module nsmd_checker #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic        [VALUE_WIDTH-1:0] max_diff,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted frame state.
  int frame_vals [MAX_ELEMENTS];
  int left_nb    [MAX_ELEMENTS];
  int mono       [MAX_ELEMENTS];
  int sp;
  int n_elems;

  logic [VALUE_WIDTH-1:0] frame_max_diffs [$];
  logic [VALUE_WIDTH-1:0] want_diff;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // Pop every entry that is not strictly smaller, take the top as the
  // neighbor (zero on an empty stack), then push the new value.
  function automatic int nearest_smaller_push(int v);
    int nb;
    while (sp > 0 && mono[sp-1] >= v) sp--;
    nb = (sp > 0) ? mono[sp-1] : 0;
    if (sp < MAX_ELEMENTS) begin
      mono[sp] = v;
      sp++;
    end
    return nb;
  endfunction

  // Right-to-left pass over the stored elements, then clear the frame.
  function automatic logic [VALUE_WIDTH-1:0] close_frame();
    int best;
    int right;
    int d;
    best = 0;
    sp   = 0;
    for (int i = n_elems; i > 0; i--) begin
      right = nearest_smaller_push(frame_vals[i-1]);
      d     = left_nb[i-1] - right;
      if (d < 0) d = -d;
      if (d > best) best = d;
    end
    sp      = 0;
    n_elems = 0;
    return best[VALUE_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sp           = 0;
      n_elems      = 0;
      fail_count   = 0;
      results_seen = 0;
      frame_max_diffs.delete();
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (frame_max_diffs.size() == 0) begin
          report_mismatch($sformatf("result max_diff=%0d with no frame closed", max_diff));
        end else begin
          want_diff = frame_max_diffs.pop_front();
          if (max_diff !== want_diff)
            report_mismatch($sformatf("max_diff got %0d, want %0d", max_diff, want_diff));
        end
      end
      if (item_valid && !item_stall) begin
        // Elements past the capacity are dropped, but their last still closes.
        if (n_elems < MAX_ELEMENTS) begin
          frame_vals[n_elems] = value;
          left_nb[n_elems]    = nearest_smaller_push(value);
          n_elems++;
        end
        if (last) frame_max_diffs.push_back(close_frame());
      end
    end
    pending = frame_max_diffs.size();
  end

endmodule

FILE: tb/nearest_smaller_max_diff_unit_tb.sv
// Top of the testbench for the nearest smaller max diff unit: clock, reset,
// frame stimulus, result-side stalling and the verdict.
// Depends on nearest_smaller_max_diff_unit and on nsmd_checker in this folder.
module nearest_smaller_max_diff_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_WIDTH  = 16;
  // Length of the one long result hold-off, in cycles. It is far longer than
  // a few short frames take, so the unit fills up and stalls its input.
  localparam int HOLD_CYCLES  = 3000;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  logic signed [VALUE_WIDTH-1:0] value        = '0;
  logic                          last         = 1'b0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic        [VALUE_WIDTH-1:0] max_diff;

  int   fail_count;
  int   pending;
  int   results_seen;

  // Idling mix of the current phase, in percent of cycles.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;

  int   items_sent  = 0;
  int   frames_sent = 0;

  nearest_smaller_max_diff_unit #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .last        (last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .max_diff    (max_diff)
  );

  // The checker sees exactly what the unit sees and keeps the expectations.
  nsmd_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .last        (last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .max_diff    (max_diff),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side. Every cycle it decides the stall for the next cycle from the
  // phase's stall rate. When the stimulus raises hold_req, it stalls without
  // a break through the long hold-off, counted here, and then goes back to random.
  initial begin : result_side
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one request and returns right after the edge that accepts it. The
  // gap before it is geometric, so the sender idles in about send_idle_pct of
  // the cycles. Valid is lowered only when a gap follows, so it is never
  // lowered and raised in the same step, and a stalled payload stays put.
  task automatic send_item(input int v, input logic is_last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v[VALUE_WIDTH-1:0];
    last       <= is_last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (is_last) frames_sent++;
  endtask

  // Sends a fixed frame, the last element carrying last.
  task automatic send_values(input int vals[$]);
    for (int i = 0; i < vals.size(); i++) send_item(vals[i], i == vals.size() - 1);
  endtask

  // Element values by frame style: full range, a narrow band around zero that
  // gives many equal neighbors, or the field extremes mixed with full range.
  function automatic int pick_value(int style);
    int extremes[7];
    extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    if (style <= 4) return int'($urandom_range(65535)) - 32768;
    if (style <= 7) return int'($urandom_range(6)) - 3;
    if ($urandom_range(1) == 0) return extremes[$urandom_range(6)];
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic send_frame(input int len);
    int style;
    style = $urandom_range(9);
    for (int i = 0; i < len; i++) send_item(pick_value(style), i == len - 1);
  endtask

  // Mostly short frames; a few reach a hundred or more elements.
  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(150, 41);
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = items_sent;
    while (items_sent - start < n_items) send_frame(pick_frame_len());
  endtask

  initial begin : stimulus
    int dir[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames, with no idling. Single elements at both extremes have
    // no neighbors at all and give zero.
    dir = '{-32768};
    send_values(dir);
    dir = '{32767};
    send_values(dir);
    // The widest spread in each direction: left neighbor near the top and
    // right neighbor at the bottom, then the other way around.
    dir = '{32766, 32767, -32768};
    send_values(dir);
    dir = '{-32768, 32767, 32766};
    send_values(dir);
    // A missing neighbor on one side against the most negative value.
    dir = '{32767, -32768, 32767};
    send_values(dir);
    // Equal values are not strictly smaller, so they pop each other.
    dir = '{7, 7, 7};
    send_values(dir);
    // Rising and falling runs across zero.
    dir = '{-1, 0, 1, 2};
    send_values(dir);
    dir = '{3, 2, 1, 0, -1};
    send_values(dir);

    // Random frames, no idling on either side.
    run_phase(0, 0, 230);

    // Long hold-off on the result side while short frames keep arriving
    // back to back: the output register fills, the next frame closes behind
    // it and the input stalls until the hold-off ends.
    hold_req <= 1'b1;
    for (int f = 0; f < 20; f++) send_frame(3);

    // Sender idling. One frame runs past the capacity, so its tail is dropped
    // while its last element still closes the frame.
    run_phase(77, 0, 230);
    send_frame(MAX_ELEMENTS + 2);

    // Receiver stalling.
    run_phase(0, 77, 230);

    // Both sides idle now and then.
    run_phase(23, 23, 230);

    item_valid <= 1'b0;
    @(posedge clk);
    // A full frame needs a whole right-to-left pass to finish after its last element,
    // so wait on the checker rather than on a cycle count, then wait a while longer
    // to catch any stray result.
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Run covered %0d input requests in %0d frames; %0d result requests checked.",
             items_sent, frames_sent, results_seen);
    $display("Included field extremes, equal runs, single and overlong frames, "
             , "four idling mixes and a long result hold-off.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin : watchdog
    #20000000;
    $display("Timeout: results still outstanding or input never accepted.");
    $display("Some tests failed");
    $finish;
  end

endmodule
